// File: rtl/tpr_pkg.sv
`timescale 1ns / 1ps

package tpr_pkg;

   localparam int unsigned RESULT_SLOTS = 3;

   localparam logic [7:0]  START_BYTE0  = 8'h00;
   localparam logic [7:0]  START_BYTE1  = 8'h00;
   localparam logic [7:0]  START_BYTE2  = 8'h01;
   localparam logic [16:0] HEADER_EXTRA = 17'd6;
   localparam logic [16:0] COPIED_MAX   = 17'h1FFFF;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_END   = 2'd1,
      CMD_FLUSH = 2'd2
   } tpr_cmd_type;

   typedef struct packed {
      logic [7:0]  payload_bytes;
      logic        start_flag;
      logic        is_duplicate;
      logic        is_scrambled;
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      logic [7:0]  third_byte;
      logic [7:0]  length_high;
      logic [7:0]  length_low;
      logic [15:0] space_free;
   } tpr_req_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  write_len;
      logic [15:0] packets_started;
      logic        last;
   } tpr_rsp_type;

   typedef struct packed {
      logic        in_packet;
      logic [16:0] expected_len;
      logic [16:0] copied_len;
      logic [15:0] start_count;
   } tpr_state_type;

   typedef struct packed {
      logic [1:0]                         count;
      tpr_cmd_type [RESULT_SLOTS-1:0]     cmd;
      logic [RESULT_SLOTS-1:0][7:0]       wlen;
      logic [15:0]                        started;
   } tpr_result_type;

endpackage

// File: rtl/tpr_frame.sv
`timescale 1ns / 1ps

module tpr_frame import tpr_pkg::*; #(
   parameter int unsigned MAX_PAYLOAD = 184
) (
   input  logic           service_enable,
   input  tpr_req_type    item,
   input  tpr_state_type  state_cur,
   output tpr_state_type  state_nxt,
   output tpr_result_type result
);

   logic        accept_item;
   logic        start_code;
   logic        pre_end;
   logic        mid_present;
   logic        overflow;
   logic        post_end;
   logic [16:0] base_len;
   logic [17:0] sum_len;
   tpr_cmd_type mid_cmd;
   logic [7:0]  mid_wlen;

   always_comb begin
      accept_item = service_enable && (item.payload_bytes != 8'd0)
                    && (item.payload_bytes <= 8'(MAX_PAYLOAD)) && !item.is_duplicate;
      start_code  = item.start_flag && (item.first_byte == START_BYTE0)
                    && (item.second_byte == START_BYTE1) && (item.third_byte == START_BYTE2);
      state_nxt   = state_cur;
      pre_end     = 1'b0;
      mid_present = 1'b0;
      post_end    = 1'b0;
      overflow    = item.space_free < {8'd0, item.payload_bytes};
      base_len    = state_cur.copied_len;
      sum_len     = 18'd0;

      if (accept_item) begin
         if (item.is_scrambled) begin
            state_nxt.in_packet = 1'b0;
         end else begin
            if (start_code) begin
               state_nxt.start_count  = state_cur.start_count + 16'd1;
               pre_end                = state_cur.in_packet;
               state_nxt.in_packet    = 1'b1;
               state_nxt.expected_len = {1'b0, item.length_high, item.length_low}
                                        + HEADER_EXTRA;
               base_len               = 17'd0;
               mid_present            = 1'b1;
            end else if (state_cur.in_packet) begin
               mid_present = 1'b1;
            end
            if (mid_present) begin
               sum_len = {1'b0, base_len} + {10'd0, item.payload_bytes};
               if (overflow) begin
                  state_nxt.in_packet = 1'b0;
               end else begin
                  state_nxt.copied_len = sum_len[17] ? COPIED_MAX : sum_len[16:0];
               end
            end
            if (!(mid_present && overflow) && state_nxt.in_packet
                && (state_nxt.expected_len != HEADER_EXTRA)
                && (state_nxt.copied_len >= state_nxt.expected_len)) begin
               post_end            = 1'b1;
               state_nxt.in_packet = 1'b0;
            end
         end
      end
   end

   always_comb begin
      mid_cmd        = overflow ? CMD_FLUSH : CMD_WRITE;
      mid_wlen       = overflow ? 8'd0 : item.payload_bytes;
      result.count   = {1'b0, pre_end} + {1'b0, mid_present} + {1'b0, post_end};
      result.started = state_nxt.start_count;
      result.cmd[2]  = CMD_END;
      result.wlen[2] = 8'd0;
      if (pre_end) begin
         result.cmd[0]  = CMD_END;
         result.wlen[0] = 8'd0;
         result.cmd[1]  = mid_cmd;
         result.wlen[1] = mid_wlen;
      end else begin
         result.cmd[0]  = mid_cmd;
         result.wlen[0] = mid_wlen;
         result.cmd[1]  = CMD_END;
         result.wlen[1] = 8'd0;
      end
   end

endmodule

// File: rtl/ts_to_pes_reassembly.sv
`timescale 1ns / 1ps

// PES framing for the transport packets of one PID. One descriptor can be
// taken every cycle unless req_stall is high: it is registered, then the
// framing state is updated in a single pass and its commands (up to three:
// optional end of the open packet, write or flush, optional end on reaching
// the PES length) are loaded into a result buffer that drives one word per
// cycle on the rsp channel unless rsp_stall is high. A descriptor with words
// waits in the input register until the last word of the buffer is taken;
// descriptors that yield no word never wait on rsp.
module ts_to_pes_reassembly import tpr_pkg::*; #(
   parameter int unsigned MAX_PAYLOAD = 184
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  tpr_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tpr_rsp_type rsp_word
);

   logic           service_enable_ff;
   logic           in_valid_ff, in_valid_in;
   tpr_req_type    in_word_ff;
   tpr_state_type  state_ff;
   tpr_state_type  state_in;
   tpr_state_type  state_calc;
   tpr_result_type result;

   logic                             bnd_valid_ff;
   logic [1:0]                       bnd_count_ff;
   logic [1:0]                       bnd_idx_ff;
   tpr_cmd_type [RESULT_SLOTS-1:0]   bnd_cmd_ff;
   logic [RESULT_SLOTS-1:0][7:0]     bnd_wlen_ff;
   logic [15:0]                      bnd_started_ff;

   logic bnd_last;
   logic take_last;
   logic bnd_free;
   logic advance;
   logic req_take;
   logic enable_rise;

   tpr_frame #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_frame (
      .service_enable (service_enable_ff),
      .item           (in_word_ff),
      .state_cur      (state_ff),
      .state_nxt      (state_calc),
      .result         (result)
   );

   assign bnd_last  = bnd_idx_ff == (bnd_count_ff - 2'd1);
   assign take_last = bnd_valid_ff && !rsp_stall && bnd_last;
   assign bnd_free  = !bnd_valid_ff || take_last;
   assign advance   = in_valid_ff && ((result.count == 2'd0) || bnd_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   assign enable_rise = csr_wr_en && csr_wr_data && !service_enable_ff;

   // enabling the service restarts the start-code hunt
   always_comb begin
      state_in = advance ? state_calc : state_ff;
      if (enable_rise) begin
         state_in.in_packet = 1'b0;
      end
   end

   assign rsp_valid                = bnd_valid_ff;
   assign rsp_word.command         = bnd_cmd_ff[bnd_idx_ff];
   assign rsp_word.write_len       = bnd_wlen_ff[bnd_idx_ff];
   assign rsp_word.packets_started = bnd_started_ff;
   assign rsp_word.last            = bnd_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         service_enable_ff <= 1'b0;
         state_ff          <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            service_enable_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_valid_ff <= 1'b0;
         bnd_count_ff <= 2'd0;
         bnd_idx_ff   <= 2'd0;
      end else begin
         priority if (advance && (result.count != 2'd0)) begin
            bnd_valid_ff <= 1'b1;
            bnd_count_ff <= result.count;
            bnd_idx_ff   <= 2'd0;
         end else if (take_last) begin
            bnd_valid_ff <= 1'b0;
         end else if (bnd_valid_ff && !rsp_stall) begin
            bnd_idx_ff <= bnd_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && (result.count != 2'd0)) begin
         bnd_cmd_ff     <= result.cmd;
         bnd_wlen_ff    <= result.wlen;
         bnd_started_ff <= result.started;
      end
   end

endmodule

// File: rtl/tpr_checker.sv
`timescale 1ns / 1ps

module tpr_checker import tpr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input tpr_rsp_type rsp_word
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed under stall");

   // nothing shows right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // write carries a length, end and flush carry none
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.command == CMD_WRITE) |-> rsp_word.write_len != 8'd0)
      else $error("write with zero length");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.command != CMD_WRITE) |-> rsp_word.write_len == 8'd0)
      else $error("end or flush with nonzero length");

   // words of one descriptor follow back to back with the same start count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_word.last
      |=> rsp_valid && (rsp_word.packets_started == $past(rsp_word.packets_started)))
      else $error("results of one descriptor broken up");

endmodule

bind ts_to_pes_reassembly tpr_checker u_tpr_checker (.*);

// File: test/ts_to_pes_reassembly_tb.sv
`timescale 1ns / 1ps

module ts_to_pes_reassembly_tb;
   import tpr_pkg::*;

   localparam int unsigned PAYLOAD_MAX   = 184;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned MAX_REPORTS   = 40;
   localparam logic [23:0] START_CODE    = {START_BYTE0, START_BYTE1, START_BYTE2};

   typedef struct packed {
      tpr_req_type             word;
      logic                    typed;
      logic [1:0]              count;
      tpr_rsp_type [2:0]       res;
   } pes_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tpr_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tpr_rsp_type rsp_word;

   // pes framing tracker
   logic        svc_on = 1'b0;
   logic        in_pes = 1'b0;
   logic [16:0] pes_expect_len = '0;
   logic [16:0] pes_copied = '0;
   logic [15:0] pes_starts = '0;

   tpr_rsp_type pes_cmd_q[$];
   pes_row_type row_note_q[$];
   pes_row_type dir_rows[$];

   logic        hold_rsp = 1'b0;
   bit          no_gaps = 1'b0;
   int unsigned errors = 0;
   int unsigned items_taken = 0;
   int unsigned words_checked = 0;

   ts_to_pes_reassembly #(
      .MAX_PAYLOAD(PAYLOAD_MAX)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("ts_to_pes_reassembly test failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   function automatic int unsigned idle_gap();
      int unsigned r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic tpr_req_type desc(input logic [7:0] plen, input logic us,
                                        input logic [23:0] code, input logic [15:0] pes_len,
                                        input logic [15:0] space, input logic dup = 1'b0,
                                        input logic scr = 1'b0);
      tpr_req_type w;
      w.payload_bytes = plen;
      w.start_flag    = us;
      w.is_duplicate  = dup;
      w.is_scrambled  = scr;
      {w.first_byte, w.second_byte, w.third_byte} = code;
      {w.length_high, w.length_low} = pes_len;
      w.space_free    = space;
      return w;
   endfunction

   function automatic tpr_rsp_type cmd(input tpr_cmd_type c, input logic [7:0] wlen,
                                       input logic [15:0] started, input logic fin);
      tpr_rsp_type r;
      r.command         = c;
      r.write_len       = wlen;
      r.packets_started = started;
      r.last            = fin;
      return r;
   endfunction

   // n < 0: no typed expectation, the tracker decides
   function automatic pes_row_type row(input tpr_req_type w, input int n,
                                       input tpr_rsp_type r0 = '0, input tpr_rsp_type r1 = '0,
                                       input tpr_rsp_type r2 = '0);
      pes_row_type r;
      r.word  = w;
      r.typed = (n >= 0);
      r.count = (n < 0) ? 2'd0 : n[1:0];
      r.res   = {r2, r1, r0};
      return r;
   endfunction

   task automatic predict_word(input tpr_req_type w, output int n,
                               output tpr_rsp_type [2:0] res);
      tpr_cmd_type cmds[3];
      logic [7:0]  lens[3];
      logic [17:0] sum;
      bit          halted;
      n = 0;
      res = '0;
      halted = 0;
      if (!svc_on || w.payload_bytes == 0 || w.payload_bytes > PAYLOAD_MAX || w.is_duplicate)
         return;
      if (w.is_scrambled) begin
         in_pes = 1'b0;
         return;
      end
      if (w.start_flag && {w.first_byte, w.second_byte, w.third_byte} == START_CODE) begin
         pes_starts = pes_starts + 16'd1;
         if (in_pes) begin
            cmds[n] = CMD_END;
            lens[n] = 8'd0;
            n++;
         end
         in_pes = 1'b1;
         pes_expect_len = {1'b0, w.length_high, w.length_low} + HEADER_EXTRA;
         pes_copied = '0;
      end
      if (in_pes) begin
         if (w.space_free < w.payload_bytes) begin
            cmds[n] = CMD_FLUSH;
            lens[n] = 8'd0;
            n++;
            in_pes = 1'b0;
            halted = 1;
         end else begin
            cmds[n] = CMD_WRITE;
            lens[n] = w.payload_bytes;
            n++;
            sum = {1'b0, pes_copied} + w.payload_bytes;
            pes_copied = (sum > COPIED_MAX) ? COPIED_MAX : sum[16:0];
         end
      end
      if (!halted && in_pes && pes_expect_len != HEADER_EXTRA
          && pes_copied >= pes_expect_len) begin
         cmds[n] = CMD_END;
         lens[n] = 8'd0;
         n++;
         in_pes = 1'b0;
      end
      for (int i = 0; i < n; i++) res[i] = cmd(cmds[i], lens[i], pes_starts, i == n - 1);
   endtask

   always @(posedge clock) begin : req_monitor
      pes_row_type       note;
      int                n;
      tpr_rsp_type [2:0] got;
      if (reset) begin
         svc_on = 1'b0;
         in_pes = 1'b0;
         pes_expect_len = '0;
         pes_copied = '0;
         pes_starts = '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_wr_data && !svc_on) in_pes = 1'b0;
            svc_on = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            note = row_note_q.pop_front();
            predict_word(req_word, n, got);
            if (note.typed) begin
               n = int'(note.count);
               got = note.res;
            end
            for (int i = 0; i < n; i++) pes_cmd_q.push_back(got[i]);
            items_taken++;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      tpr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pes_cmd_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word cmd=%0d len=%0d", rsp_word.command,
                                      rsp_word.write_len));
         end else begin
            want = pes_cmd_q.pop_front();
            if (rsp_word.command !== want.command)
               report_mismatch($sformatf("command %0d, expected %0d", rsp_word.command,
                                         want.command));
            if (rsp_word.write_len !== want.write_len)
               report_mismatch($sformatf("write_len %0d, expected %0d", rsp_word.write_len,
                                         want.write_len));
            if (rsp_word.packets_started !== want.packets_started)
               report_mismatch($sformatf("packets_started %0d, expected %0d",
                                         rsp_word.packets_started, want.packets_started));
            if (rsp_word.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_word.last, want.last));
         end
      end
   end

   // receiver: random stalls, plus one long hold when asked
   initial begin : rsp_side
      int unsigned n;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            n = HOLD_CYCLES;
            hold_rsp <= 1'b0;
         end else begin
            n = idle_gap();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (idle_gap()) @(posedge clock);
      end
   end

   task automatic send_word(input tpr_req_type w, input pes_row_type note);
      int unsigned gap;
      row_note_q.push_back(note);
      req_word <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pes_cmd_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_service(input logic on);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic tpr_req_type random_word();
      tpr_req_type w;
      int unsigned r;
      int unsigned q;
      logic [15:0] pes_len;
      w.payload_bytes = 8'($urandom_range(0, 255));
      w.start_flag    = 1'($urandom_range(0, 1));
      w.is_duplicate  = 1'($urandom_range(0, 1));
      w.is_scrambled  = 1'($urandom_range(0, 1));
      w.first_byte    = 8'($urandom_range(0, 255));
      w.second_byte   = 8'($urandom_range(0, 255));
      w.third_byte    = 8'($urandom_range(0, 255));
      w.length_high   = 8'($urandom_range(0, 255));
      w.length_low    = 8'($urandom_range(0, 255));
      w.space_free    = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 12) return w;
      w.is_duplicate  = ($urandom_range(0, 29) == 0);
      w.is_scrambled  = ($urandom_range(0, 39) == 0);
      w.payload_bytes = ($urandom_range(0, 2) == 0) ? 8'(PAYLOAD_MAX)
                                                    : 8'($urandom_range(1, PAYLOAD_MAX));
      w.space_free    = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, w.payload_bytes))
                                                     : 16'($urandom_range(w.payload_bytes,
                                                                          65535));
      if (r < 40) begin
         w.start_flag = 1'b1;
         {w.first_byte, w.second_byte, w.third_byte} = START_CODE;
         q = $urandom_range(0, 9);
         if (q < 2) pes_len = '0;
         else if (q < 8) pes_len = 16'($urandom_range(1, 500));
         else pes_len = 16'($urandom_range(0, 65535));
         {w.length_high, w.length_low} = pes_len;
      end else begin
         w.start_flag = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 4) == 0) begin
            w.first_byte  = START_BYTE0;
            w.second_byte = START_BYTE1;
         end
      end
      return w;
   endfunction

   task automatic random_items(input int unsigned count);
      repeat (count) send_word(random_word(), '0);
   endtask

   initial begin : stimulus
      int unsigned directed;
      // disabled service: start code ignored
      dir_rows.push_back(row(desc(8'd10, 1'b1, START_CODE, 16'd0, 16'hFFFF), 0));
      // payload length outside 1..max, duplicate, no start code while hunting
      dir_rows.push_back(row(desc(8'd0, 1'b1, START_CODE, 16'd0, 16'hFFFF), 0));
      dir_rows.push_back(row(desc(8'd185, 1'b1, START_CODE, 16'd0, 16'hFFFF), 0));
      dir_rows.push_back(row(desc(8'd255, 1'b1, START_CODE, 16'd0, 16'hFFFF), 0));
      dir_rows.push_back(row(desc(8'd20, 1'b1, START_CODE, 16'd0, 16'hFFFF, 1'b1), 0));
      dir_rows.push_back(row(desc(8'd100, 1'b1, 24'h000002, 16'd0, 16'hFFFF), 0));
      // unbounded packet
      dir_rows.push_back(row(desc(8'd184, 1'b1, START_CODE, 16'd0, 16'hFFFF), 1,
                             cmd(CMD_WRITE, 8'd184, 16'd1, 1'b1)));
      dir_rows.push_back(row(desc(8'd184, 1'b0, 24'h123456, 16'h0000, 16'd184), 1,
                             cmd(CMD_WRITE, 8'd184, 16'd1, 1'b1)));
      // start code while inside a packet
      dir_rows.push_back(row(desc(8'd1, 1'b1, START_CODE, 16'd1, 16'hFFFF), 2,
                             cmd(CMD_END, 8'd0, 16'd2, 1'b0),
                             cmd(CMD_WRITE, 8'd1, 16'd2, 1'b1)));
      // length reached
      dir_rows.push_back(row(desc(8'd6, 1'b0, 24'hFFFFFF, 16'hFFFF, 16'd6), 2,
                             cmd(CMD_WRITE, 8'd6, 16'd2, 1'b0),
                             cmd(CMD_END, 8'd0, 16'd2, 1'b1)));
      dir_rows.push_back(row(desc(8'd10, 1'b1, START_CODE, 16'd4, 16'hFFFF), 2,
                             cmd(CMD_WRITE, 8'd10, 16'd3, 1'b0),
                             cmd(CMD_END, 8'd0, 16'd3, 1'b1)));
      // overflow on a fresh start
      dir_rows.push_back(row(desc(8'd20, 1'b1, START_CODE, 16'hFFFF, 16'd19), 1,
                             cmd(CMD_FLUSH, 8'd0, 16'd4, 1'b1)));
      dir_rows.push_back(row(desc(8'd5, 1'b0, 24'h000000, 16'd0, 16'hFFFF), 0));
      dir_rows.push_back(row(desc(8'd50, 1'b1, START_CODE, 16'hFFFF, 16'hFFFF), -1));
      // overflow on a start inside a packet
      dir_rows.push_back(row(desc(8'd30, 1'b1, START_CODE, 16'hFFFF, 16'd0), 2,
                             cmd(CMD_END, 8'd0, 16'd6, 1'b0),
                             cmd(CMD_FLUSH, 8'd0, 16'd6, 1'b1)));
      // near misses on the start code
      dir_rows.push_back(row(desc(8'd40, 1'b0, START_CODE, 16'd0, 16'hFFFF), 0));
      dir_rows.push_back(row(desc(8'd40, 1'b1, 24'hFFFFFE, 16'hFFFF, 16'hFFFF), 0));
      // scrambled drops back to hunting
      dir_rows.push_back(row(desc(8'd100, 1'b1, START_CODE, 16'd0, 16'hFFFF), 1,
                             cmd(CMD_WRITE, 8'd100, 16'd7, 1'b1)));
      dir_rows.push_back(row(desc(8'd100, 1'b0, 24'd0, 16'd0, 16'hFFFF, 1'b0, 1'b1), 0));
      dir_rows.push_back(row(desc(8'd100, 1'b0, 24'd0, 16'd0, 16'hFFFF), 0));
      dir_rows.push_back(row(desc(8'd183, 1'b1, START_CODE, 16'hFFFF, 16'hAAAA), -1));
      // three words from one descriptor
      dir_rows.push_back(row(desc(8'd7, 1'b1, START_CODE, 16'd1, 16'd7), 3,
                             cmd(CMD_END, 8'd0, 16'd9, 1'b0),
                             cmd(CMD_WRITE, 8'd7, 16'd9, 1'b0),
                             cmd(CMD_END, 8'd0, 16'd9, 1'b1)));
      dir_rows.push_back(row(desc(8'd184, 1'b1, START_CODE, 16'h1000, 16'h5555), -1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (i == 1) set_service(1'b1);
         send_word(dir_rows[i].word, dir_rows[i]);
      end
      directed = dir_rows.size();

      // toggling the service mid-packet forces hunting
      set_service(1'b0);
      send_word(desc(8'd10, 1'b0, 24'd0, 16'd0, 16'hFFFF), '0);
      set_service(1'b1);
      send_word(desc(8'd10, 1'b0, 24'd0, 16'd0, 16'hFFFF), '0);

      random_items(120);

      // receiver holds off while the sender keeps offering
      hold_rsp <= 1'b1;
      no_gaps = 1'b1;
      random_items(40);
      no_gaps = 1'b0;
      drain();

      no_gaps = 1'b1;
      random_items(60);
      no_gaps = 1'b0;

      set_service(1'b0);
      random_items(20);
      set_service(1'b1);
      random_items(180);

      drain();
      $display("%0d descriptors taken (%0d directed), %0d command words checked,",
               items_taken, directed, words_checked);
      $display("%0d PES starts seen, service toggled off and on twice", pes_starts);
      if (errors == 0) begin
         $display("ts_to_pes_reassembly test passed");
      end else begin
         $display("ts_to_pes_reassembly test failed");
      end
      $finish;
   end

endmodule
